[sv/negabinary_gather_schedule_top_macros.svh]
// Assertion macros shared by the schedule generator RTL.
`ifndef NEGABINARY_GATHER_SCHEDULE_TOP_MACROS_SVH
`define NEGABINARY_GATHER_SCHEDULE_TOP_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define NGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define NGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ngs_pkg.sv]
`timescale 1ns / 1ps
package ngs_pkg;

	// Group limits
	localparam int MAX_RANKS = 1024;
	localparam int SIZE_CAP  = (MAX_RANKS < 1024) ? MAX_RANKS : 1024;

	// Field widths
	localparam int RANK_W = 10;
	localparam int SIZE_W = 11;
	localparam int KIND_W = 2;
	localparam int BE_W   = 21;
	localparam int EB_W   = 5;
	localparam int BEEB_W = BE_W + EB_W;
	localparam int ECNT_W = 31;
	localparam int BOFF_W = 34;

	// Negabinary word and remainder unit widths
	localparam int NEGA_W = 12;
	localparam int SUM_W  = 16;
	localparam int MAG_W  = 12;
	localparam int CNT_W  = $clog2(MAG_W);

	// Descriptor kinds
	localparam logic [KIND_W-1:0] KIND_COPY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RECV = 2'd2;

	// Register file
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_BLOCK_ELEMS = 1'b0;
	localparam logic REG_ELEM_BYTES  = 1'b1;
	localparam logic [BE_W-1:0] BLOCK_ELEMS_RST = 21'd1;
	localparam logic [EB_W-1:0] ELEM_BYTES_RST  = 5'd4;

	// Remainder unit operand select
	typedef enum logic [1:0] {
		MOD_SEL_OWN  = 2'd0,
		MOD_SEL_ROOT = 2'd1,
		MOD_SEL_PART = 2'd2
	} mod_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     load;
		logic     mod_start;
		mod_sel_t mod_sel;
		logic     take_rank;
		logic     init;
		logic     decide;
		logic     calc;
		logic     next_piece;
	} ngs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mod_busy;
		logic mod_done;
		logic split;
		logic second;
		logic last;
	} ngs_sts_t;

endpackage

[sv/ngs_req_if.sv]
`timescale 1ns / 1ps
interface ngs_req_if
	import ngs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] own_rank;
	logic [RANK_W-1:0] root_rank;
	logic [SIZE_W-1:0] group_size;

	modport source (output valid, own_rank, root_rank, group_size, input ready);
	modport sink (input valid, own_rank, root_rank, group_size, output ready);
endinterface

[sv/ngs_desc_if.sv]
`timescale 1ns / 1ps
interface ngs_desc_if
	import ngs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [RANK_W-1:0] partner;
	logic [RANK_W-1:0] first_block;
	logic [SIZE_W-1:0] block_count;
	logic [ECNT_W-1:0] element_count;
	logic [BOFF_W-1:0] byte_offset;
	logic              last;

	modport source (
		output valid, kind, partner, first_block, block_count, element_count,
		byte_offset, last,
		input ready
	);
	modport sink (
		input valid, kind, partner, first_block, block_count, element_count,
		byte_offset, last,
		output ready
	);
endinterface

[sv/ngs_mod.sv]
`timescale 1ns / 1ps
`include "negabinary_gather_schedule_top_macros.svh"
// Signed value modulo group size, restoring form, one dividend bit per cycle.
module ngs_mod
	import ngs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              neg,
	input  logic [MAG_W-1:0]  mag,
	input  logic [SIZE_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [RANK_W-1:0] result
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  quo_q;
	logic [RANK_W-1:0] rem_q;
	logic              neg_q;
	logic [SIZE_W-1:0] div_q;

	logic [SIZE_W-1:0] trial;
	logic              fits;
	logic [RANK_W-1:0] rem_nxt;
	logic              go;

	assign go = start && !busy_q;

	// One restoring step: shift in next bit, subtract if it fits
	assign trial   = {rem_q, quo_q[MAG_W-1]};
	assign fits    = trial >= div_q;
	assign rem_nxt = fits ? RANK_W'(trial - div_q) : trial[RANK_W-1:0];

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(MAG_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and remainder registers
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= neg;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	// Negative dividend: fold remainder back into range
	assign result = (neg_q && rem_q != '0) ? RANK_W'(div_q - {1'b0, rem_q}) : rem_q;
	assign busy   = busy_q;
	assign done   = done_q;

	`NGS_ASSERT_NOW(a_mod_in_range, clk, arst_n, done_q, ({1'b0, result} < div_q), "remainder not below group size")

endmodule

[sv/ngs_dp.sv]
`timescale 1ns / 1ps
`include "negabinary_gather_schedule_top_macros.svh"
module ngs_dp
	import ngs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ngs_cmd_t          cmd,
	output ngs_sts_t          sts,
	input  logic [RANK_W-1:0] own_rank,
	input  logic [RANK_W-1:0] root_rank,
	input  logic [SIZE_W-1:0] group_size,
	input  logic [BE_W-1:0]   block_elems,
	input  logic [EB_W-1:0]   elem_bytes,
	output logic [KIND_W-1:0] kind,
	output logic [RANK_W-1:0] partner,
	output logic [RANK_W-1:0] first_block,
	output logic [SIZE_W-1:0] block_count,
	output logic [ECNT_W-1:0] element_count,
	output logic [BOFF_W-1:0] byte_offset,
	output logic              last
);

	localparam int ECNT_FULL_W = SIZE_W + BE_W;
	localparam int BOFF_FULL_W = RANK_W + BEEB_W;

	// Request registers
	logic [RANK_W-1:0] own_q, root_q, rank_q, rootm_q;
	logic [SIZE_W-1:0] size_q;
	logic [NEGA_W-1:0] nv_q;
	logic [SIZE_W-1:0] mask_q;
	logic              grow_q;
	logic [RANK_W-1:0] lo_q, hi_q;

	// Pending descriptor
	logic [KIND_W-1:0] kind_q;
	logic [RANK_W-1:0] partner_q, rlo_q, rhi_q;
	logic              last_q;
	logic              sel_q;

	// Output beat
	logic [KIND_W-1:0] kind_o_q;
	logic [RANK_W-1:0] partner_o_q, first_o_q;
	logic [SIZE_W-1:0] count_o_q;
	logic [ECNT_W-1:0] ecnt_o_q;
	logic [BOFF_W-1:0] boff_o_q;
	logic              last_o_q;

	logic [BEEB_W-1:0] beeb_q;

	// Remainder unit
	logic              mod_neg, mod_busy, mod_done;
	logic [MAG_W-1:0]  mod_mag;
	logic [RANK_W-1:0] mod_res;

	logic [SIZE_W-1:0] size_in;
	logic [SIZE_W-1:0] vr;
	logic [NEGA_W-1:0] mask2, mlsb, lsbs, pn;
	logic [SUM_W-1:0]  pval, psum, pabs;
	logic              equal, do_send;
	logic [SIZE_W-1:0] hi1;
	logic [NEGA_W-1:0] him, lom;
	logic [RANK_W-1:0] up_rs, up_re, dn_rs, dn_re;
	logic              split;
	logic [RANK_W-1:0] first_c;
	logic [SIZE_W-1:0] count_c;
	logic [ECNT_FULL_W-1:0] ecnt_full;
	logic [BOFF_FULL_W-1:0] boff_full;

	// Group size clamp
	always_comb begin
		if (group_size == '0) begin
			size_in = SIZE_W'(1);
		end else if (group_size > SIZE_W'(SIZE_CAP)) begin
			size_in = SIZE_W'(SIZE_CAP);
		end else begin
			size_in = group_size;
		end
	end

	// Virtual rank, from rank and the root remainder just produced
	assign vr = (rank_q >= mod_res) ? SIZE_W'(rank_q - mod_res)
		: SIZE_W'({1'b0, rank_q} + size_q - {1'b0, mod_res});

	// Partner in negabinary, back to a signed value, plus root
	assign mask2 = {mask_q, 1'b0};
	assign pn    = nv_q ^ (mask2 - NEGA_W'(1));
	assign pval  = ({{(SUM_W-NEGA_W){1'b0}}, pn} ^ 16'hAAAA) - 16'hAAAA;
	assign psum  = pval + {{(SUM_W-RANK_W){1'b0}}, rootm_q};
	assign pabs  = psum[SUM_W-1] ? (~psum + SUM_W'(1)) : psum;

	// Low-bit test: all zero or all one below four times the mask
	assign mlsb    = {mask_q[NEGA_W-3:0], 2'b00} - NEGA_W'(1);
	assign lsbs    = nv_q & mlsb;
	assign equal   = (lsbs == '0) || (lsbs == mlsb);
	assign do_send = !equal || ((mask2 >= {1'b0, size_q}) && (rank_q != rootm_q));

	// Range growing upward
	assign hi1   = {1'b0, hi_q} + SIZE_W'(1);
	assign up_rs = (hi1 == size_q) ? '0 : hi1[RANK_W-1:0];
	assign him   = {2'b00, hi_q} + {1'b0, mask_q};
	assign up_re = (him >= {1'b0, size_q}) ? RANK_W'(him - {1'b0, size_q}) : him[RANK_W-1:0];

	// Range growing downward
	assign dn_re = (lo_q == '0) ? RANK_W'(size_q - SIZE_W'(1)) : RANK_W'(lo_q - RANK_W'(1));
	assign lom   = {2'b00, lo_q} + {1'b0, size_q} - {1'b0, mask_q};
	assign dn_rs = ({1'b0, lo_q} >= mask_q) ? RANK_W'({1'b0, lo_q} - mask_q)
		: lom[RANK_W-1:0];

	// Remainder operand select
	always_comb begin
		mod_neg = 1'b0;
		mod_mag = {{(MAG_W-RANK_W){1'b0}}, own_q};
		case (cmd.mod_sel)
			MOD_SEL_OWN: begin
				mod_mag = {{(MAG_W-RANK_W){1'b0}}, own_q};
			end
			MOD_SEL_ROOT: begin
				mod_mag = {{(MAG_W-RANK_W){1'b0}}, root_q};
			end
			MOD_SEL_PART: begin
				mod_neg = psum[SUM_W-1];
				mod_mag = pabs[MAG_W-1:0];
			end
			default: begin
				mod_mag = {{(MAG_W-RANK_W){1'b0}}, own_q};
			end
		endcase
	end

	ngs_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mod_start),
		.neg     (mod_neg),
		.mag     (mod_mag),
		.divisor (size_q),
		.busy    (mod_busy),
		.done    (mod_done),
		.result  (mod_res)
	);

	// Current piece of the pending range (wrapped ranges split in two)
	assign split   = rhi_q < rlo_q;
	assign first_c = sel_q ? '0 : rlo_q;
	always_comb begin
		if (sel_q) begin
			count_c = {1'b0, rhi_q} + SIZE_W'(1);
		end else if (split) begin
			count_c = size_q - {1'b0, rlo_q};
		end else begin
			count_c = {1'b0, rhi_q} - {1'b0, rlo_q} + SIZE_W'(1);
		end
	end

	assign ecnt_full = ECNT_FULL_W'(count_c) * ECNT_FULL_W'(block_elems);
	assign boff_full = BOFF_FULL_W'(first_c) * BOFF_FULL_W'(beeb_q);

	// Bytes per block, held ready for the offset multiply
	always_ff @(posedge clk) begin
		beeb_q <= BEEB_W'(BEEB_W'(block_elems) * BEEB_W'(elem_bytes));
	end

	// Mask and piece select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= SIZE_W'(1);
			sel_q  <= 1'b0;
		end else if (cmd.init) begin
			mask_q <= SIZE_W'(1);
			sel_q  <= 1'b0;
		end else if (cmd.decide) begin
			sel_q <= 1'b0;
			if (!do_send) begin
				mask_q <= mask2[SIZE_W-1:0];
			end
		end else if (cmd.next_piece) begin
			sel_q <= 1'b1;
		end
	end

	// Request state and pending descriptor
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			own_q  <= own_rank;
			root_q <= root_rank;
			size_q <= size_in;
		end
		if (cmd.take_rank) begin
			rank_q <= mod_res;
		end
		if (cmd.init) begin
			rootm_q   <= mod_res;
			nv_q      <= (NEGA_W'(vr) + 12'hAAA) ^ 12'hAAA;
			lo_q      <= rank_q;
			hi_q      <= rank_q;
			grow_q    <= !rank_q[0];
			kind_q    <= KIND_COPY;
			partner_q <= rank_q;
			rlo_q     <= rank_q;
			rhi_q     <= rank_q;
			last_q    <= size_q == SIZE_W'(1);
		end
		if (cmd.decide) begin
			partner_q <= mod_res;
			if (do_send) begin
				kind_q <= KIND_SEND;
				rlo_q  <= lo_q;
				rhi_q  <= hi_q;
				last_q <= 1'b1;
			end else begin
				kind_q <= KIND_RECV;
				last_q <= mask2 >= {1'b0, size_q};
				grow_q <= !grow_q;
				if (grow_q) begin
					rlo_q <= up_rs;
					rhi_q <= up_re;
					hi_q  <= up_re;
				end else begin
					rlo_q <= dn_rs;
					rhi_q <= dn_re;
					lo_q  <= dn_rs;
				end
			end
		end
	end

	// Output beat
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			kind_o_q    <= kind_q;
			partner_o_q <= partner_q;
			first_o_q   <= first_c;
			count_o_q   <= count_c;
			ecnt_o_q    <= ecnt_full[ECNT_W-1:0];
			boff_o_q    <= boff_full[BOFF_W-1:0];
			last_o_q    <= last_q && (sel_q || !split);
		end
	end

	assign kind          = kind_o_q;
	assign partner       = partner_o_q;
	assign first_block   = first_o_q;
	assign block_count   = count_o_q;
	assign element_count = ecnt_o_q;
	assign byte_offset   = boff_o_q;
	assign last          = last_o_q;

	assign sts.mod_busy = mod_busy;
	assign sts.mod_done = mod_done;
	assign sts.split    = split;
	assign sts.second   = sel_q;
	assign sts.last     = last_o_q;

	`NGS_ASSERT_NOW(a_mask_pow2, clk, arst_n, 1'b1, $onehot(mask_q), "mask is not a power of two")

endmodule

[sv/ngs_ctrl.sv]
`timescale 1ns / 1ps
`include "negabinary_gather_schedule_top_macros.svh"
module ngs_ctrl
	import ngs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ngs_cmd_t cmd,
	input  ngs_sts_t sts
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_MOD_RANK = 6'b000010,
		ST_MOD_ROOT = 6'b000100,
		ST_MOD_PART = 6'b001000,
		ST_CALC     = 6'b010000,
		ST_SHOW     = 6'b100000
	} state_t;

	state_t st_q, st_nxt;

	// Next state and datapath commands
	always_comb begin
		st_nxt = st_q;
		cmd    = '0;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_nxt   = ST_MOD_RANK;
				end
			end
			ST_MOD_RANK: begin
				cmd.mod_sel   = MOD_SEL_OWN;
				cmd.mod_start = !sts.mod_busy && !sts.mod_done;
				if (sts.mod_done) begin
					cmd.take_rank = 1'b1;
					st_nxt        = ST_MOD_ROOT;
				end
			end
			ST_MOD_ROOT: begin
				cmd.mod_sel   = MOD_SEL_ROOT;
				cmd.mod_start = !sts.mod_busy && !sts.mod_done;
				if (sts.mod_done) begin
					cmd.init = 1'b1;
					st_nxt   = ST_CALC;
				end
			end
			ST_MOD_PART: begin
				cmd.mod_sel   = MOD_SEL_PART;
				cmd.mod_start = !sts.mod_busy && !sts.mod_done;
				if (sts.mod_done) begin
					cmd.decide = 1'b1;
					st_nxt     = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				st_nxt   = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_ready) begin
					if (sts.last) begin
						st_nxt = ST_IDLE;
					end else if (sts.split && !sts.second) begin
						cmd.next_piece = 1'b1;
						st_nxt         = ST_CALC;
					end else begin
						st_nxt = ST_MOD_PART;
					end
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	assign in_ready  = st_q == ST_IDLE;
	assign out_valid = st_q == ST_SHOW;

	`NGS_ASSERT_NEXT(a_accept_starts, clk, arst_n, st_q == ST_IDLE && in_valid, st_q == ST_MOD_RANK, "accepted request did not start rank reduction")
	`NGS_ASSERT_NEXT(a_show_holds, clk, arst_n, st_q == ST_SHOW && !out_ready, st_q == ST_SHOW && $stable(sts.last), "stalled beat was dropped")
	`NGS_ASSERT_NEXT(a_last_ends, clk, arst_n, st_q == ST_SHOW && out_ready && sts.last, st_q == ST_IDLE, "request not closed after last beat")

endmodule

[sv/negabinary_gather_schedule_top.sv]
// Sequence: the first beat (local copy) is shown after the request is accepted and the own and
// root ranks are reduced modulo group size. Each further descriptor follows once the previous
// beat is taken (one bit-serial remainder pass for the partner, then a product step); the
// second half of a wrapped range follows the first after another product step.
// Requests: a new request is accepted only once the last beat of the previous one is taken.
// Reset: asynchronous, active low; idle, block_elems = 1, elem_bytes = 4.
`timescale 1ns / 1ps
module negabinary_gather_schedule_top
	import ngs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	ngs_req_if.sink           req,
	ngs_desc_if.source        desc,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [BE_W-1:0] block_elems_q;
	logic [EB_W-1:0] elem_bytes_q;
	logic            cfg_wr;
	logic            reg_idx;
	ngs_cmd_t        cmd;
	ngs_sts_t        sts;

	// Register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_elems_q <= BLOCK_ELEMS_RST;
			elem_bytes_q  <= ELEM_BYTES_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_BLOCK_ELEMS: block_elems_q <= pwdata[BE_W-1:0];
				REG_ELEM_BYTES:  elem_bytes_q  <= pwdata[EB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BLOCK_ELEMS: prdata = DATA_W'(block_elems_q);
			REG_ELEM_BYTES:  prdata = DATA_W'(elem_bytes_q);
			default:         prdata = '0;
		endcase
	end

	ngs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (desc.valid),
		.out_ready (desc.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ngs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.own_rank      (req.own_rank),
		.root_rank     (req.root_rank),
		.group_size    (req.group_size),
		.block_elems   (block_elems_q),
		.elem_bytes    (elem_bytes_q),
		.kind          (desc.kind),
		.partner       (desc.partner),
		.first_block   (desc.first_block),
		.block_count   (desc.block_count),
		.element_count (desc.element_count),
		.byte_offset   (desc.byte_offset),
		.last          (desc.last)
	);

endmodule

[verif/tb_negabinary_gather_schedule_top.sv]
`timescale 1ns / 1ps
module tb_negabinary_gather_schedule_top;
	import ngs_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 9;
	localparam int IDLE_PCT     = 15;
	localparam int SETTLE_CYCLES = 32;
	localparam int STALL_LIMIT  = 3000;
	localparam logic [31:0] NEGA_ALT = 32'hAAAA_AAAA;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [RANK_W-1:0] partner;
		logic [RANK_W-1:0] first_block;
		logic [SIZE_W-1:0] block_count;
		logic [ECNT_W-1:0] element_count;
		logic [BOFF_W-1:0] byte_offset;
		logic              last;
	} sched_desc_t;

	// Schedule predictor and store of pending descriptors
	class gather_sched_sb;
		sched_desc_t       sched_q[$];
		logic [BE_W-1:0]   blk_elems;
		logic [EB_W-1:0]   el_bytes;
		int                errors;

		function new();
			blk_elems = BLOCK_ELEMS_RST;
			el_bytes  = ELEM_BYTES_RST;
			errors    = 0;
		endfunction

		function int pending();
			return sched_q.size();
		endfunction

		function void set_reg(logic idx, logic [DATA_W-1:0] val);
			if (idx == REG_BLOCK_ELEMS)
				blk_elems = val[BE_W-1:0];
			else
				el_bytes = val[EB_W-1:0];
		endfunction

		function longint pos_mod(longint a, longint m);
			longint r;
			r = a % m;
			return (r < 0) ? r + m : r;
		endfunction

		function logic [31:0] to_nega(logic [31:0] v);
			return (v + NEGA_ALT) ^ NEGA_ALT;
		endfunction

		function longint from_nega(logic [31:0] n);
			logic [31:0] x;
			x = (n ^ NEGA_ALT) - NEGA_ALT;
			return longint'($signed(x));
		endfunction

		function void add_desc(logic [KIND_W-1:0] k, longint partner, longint first,
				longint count);
			sched_desc_t d;
			d.kind          = k;
			d.partner       = RANK_W'(partner);
			d.first_block   = RANK_W'(first);
			d.block_count   = SIZE_W'(count);
			d.element_count = ECNT_W'(count * longint'(blk_elems));
			d.byte_offset   = BOFF_W'(first * longint'(blk_elems) * longint'(el_bytes));
			d.last          = 1'b0;
			sched_q.push_back(d);
		endfunction

		// a wrapped range splits into [lo..size-1] and [0..hi]
		function void add_range(logic [KIND_W-1:0] k, longint partner, longint lo,
				longint hi, longint size);
			if (hi >= lo) begin
				add_desc(k, partner, lo, hi - lo + 1);
			end else begin
				add_desc(k, partner, lo, size - lo);
				add_desc(k, partner, 0, hi + 1);
			end
		endfunction

		// accepted request: append its whole schedule
		function void note_req(logic [RANK_W-1:0] own, logic [RANK_W-1:0] root_in,
				logic [SIZE_W-1:0] gsize);
			longint      size, rank, root, lo, hi, mask, partner, rs, re;
			logic [31:0] nv, pn, mlsb, lsbs;
			logic        grow_up, aligned, done;
			size = gsize;
			if (size < 1)
				size = 1;
			if (size > SIZE_CAP)
				size = SIZE_CAP;
			rank = longint'(own) % size;
			root = longint'(root_in) % size;
			add_desc(KIND_COPY, rank, rank, 1);
			lo = rank;
			hi = rank;
			nv = to_nega(32'(pos_mod(rank - root, size)));
			grow_up = (rank % 2) == 0;
			mask = 1;
			done = 1'b0;
			while (mask < size && !done) begin
				pn = nv ^ 32'((mask << 1) - 1);
				partner = pos_mod(from_nega(pn) + root, size);
				mlsb = 32'((mask << 2) - 1);
				lsbs = nv & mlsb;
				aligned = (lsbs == 0) || (lsbs == mlsb);
				if (!aligned || ((mask << 1) >= size && rank != root)) begin
					// hand the resident range to the parent and stop
					add_range(KIND_SEND, partner, lo, hi, size);
					done = 1'b1;
				end else begin
					if (grow_up) begin
						rs = pos_mod(hi + 1, size);
						re = pos_mod(hi + mask, size);
						hi = re;
					end else begin
						re = pos_mod(lo - 1, size);
						rs = pos_mod(lo - mask, size);
						lo = rs;
					end
					add_range(KIND_RECV, partner, rs, re, size);
					grow_up = !grow_up;
					mask = mask << 1;
				end
			end
			sched_q[sched_q.size() - 1].last = 1'b1;
		endfunction

		function void cmp_field(string name, longint want, longint got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_desc(logic [KIND_W-1:0] kind, logic [RANK_W-1:0] partner,
				logic [RANK_W-1:0] first, logic [SIZE_W-1:0] count,
				logic [ECNT_W-1:0] ecnt, logic [BOFF_W-1:0] boff, logic last);
			sched_desc_t d;
			if (sched_q.size() == 0) begin
				$display("%0t: unexpected descriptor, expected none, actual kind %0d partner %0d",
					$time, kind, partner);
				errors++;
			end else begin
				d = sched_q.pop_front();
				cmp_field("kind", d.kind, kind);
				cmp_field("partner", d.partner, partner);
				cmp_field("first_block", d.first_block, first);
				cmp_field("block_count", d.block_count, count);
				cmp_field("element_count", d.element_count, ecnt);
				cmp_field("byte_offset", d.byte_offset, boff);
				cmp_field("last", d.last, last);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              no_idle = 1'b0;
	int                stall_cycles = 0;

	gather_sched_sb sb = new();

	ngs_req_if  req_bus();
	ngs_desc_if desc_bus();

	negabinary_gather_schedule_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.desc    (desc_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Descriptor sink: check each beat, then pick next ready
	always @(posedge clk) begin
		if (arst_n && desc_bus.valid && desc_bus.ready)
			sb.check_desc(desc_bus.kind, desc_bus.partner, desc_bus.first_block,
				desc_bus.block_count, desc_bus.element_count, desc_bus.byte_offset,
				desc_bus.last);
		desc_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (desc_bus.valid && desc_bus.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, stall_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_req(input logic [RANK_W-1:0] own, input logic [RANK_W-1:0] root,
			input logic [SIZE_W-1:0] gsize);
		int gap;
		gap = (!no_idle && $urandom_range(99) < IDLE_PCT) ? $urandom_range(4, 1) : 0;
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.own_rank   <= own;
		req_bus.root_rank  <= root;
		req_bus.group_size <= gsize;
		do @(posedge clk); while (!req_bus.ready);
		sb.note_req(own, root, gsize);
	endtask

	task automatic push_random_req();
		int                sel;
		logic [SIZE_W-1:0] gsize;
		logic [RANK_W-1:0] own, root;
		sel = $urandom_range(99);
		if (sel < 40)
			gsize = SIZE_W'($urandom_range(16, 1));
		else if (sel < 75)
			gsize = SIZE_W'($urandom_range(1024, 17));
		else if (sel < 85)
			gsize = SIZE_W'(SIZE_CAP);
		else if (sel < 95)
			gsize = SIZE_W'($urandom_range(2047, 1025));
		else
			gsize = SIZE_W'($urandom_range(1, 0));
		own  = RANK_W'($urandom);
		root = ($urandom_range(99) < 20) ? own : RANK_W'($urandom);
		push_req(own, root, gsize);
	endtask

	// wait for the schedule to drain, then let the block settle
	task automatic drain_sched(input int extra);
		while (sb.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, data);
		// return to idle before the next transfer
		@(posedge clk);
	endtask

	task automatic set_config(input logic [BE_W-1:0] be, input logic [EB_W-1:0] eb);
		req_bus.valid <= 1'b0;
		drain_sched(SETTLE_CYCLES);
		apb_write(REG_BLOCK_ELEMS, DATA_W'(be));
		apb_write(REG_ELEM_BYTES, DATA_W'(eb));
	endtask

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		req_bus.valid       = 1'b0;
		req_bus.own_rank    = '0;
		req_bus.root_rank   = '0;
		req_bus.group_size  = '0;
		desc_bus.ready      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: size edges, saturation, rank wrap, root placement
		push_req(10'd0, 10'd0, 11'd1);
		push_req(10'd0, 10'd0, 11'd0);
		push_req(10'd1, 10'd0, 11'd2);
		push_req(10'd0, 10'd1, 11'd2);
		push_req(10'd0, 10'd0, 11'd2);
		push_req(10'd2, 10'd0, 11'd3);
		push_req(10'd1, 10'd2, 11'd3);
		push_req(10'd3, 10'd5, 11'd5);
		push_req(10'd4, 10'd1, 11'd6);
		push_req(10'd6, 10'd6, 11'd7);
		push_req(10'd8, 10'd2, 11'd9);
		push_req(10'd0, 10'd0, 11'd1024);
		push_req(10'd1023, 10'd0, 11'd1024);
		push_req(10'd0, 10'd1023, 11'd1024);
		push_req(10'd1023, 10'd1023, 11'd1024);
		push_req(10'd512, 10'd3, 11'd1024);
		push_req(10'd5, 10'd7, 11'd2047);
		push_req(10'd1023, 10'd1023, 11'd1025);
		push_req(10'd700, 10'd100, 11'd1000);
		push_req(10'd999, 10'd0, 11'd1000);
		push_req(10'd100, 10'd50, 11'd1023);
		push_req(10'd1023, 10'd1000, 11'd511);
		push_req(10'd341, 10'd0, 11'd512);

		// Random at reset setting
		repeat (60) push_random_req();

		// Widest registers: products wrap
		set_config(21'h1F_FFFF, 5'd31);
		repeat (60) push_random_req();

		// Zero registers
		set_config(21'd0, 5'd0);
		repeat (40) push_random_req();

		set_config(21'd1, 5'd16);
		repeat (60) begin
			push_random_req();
			if ($urandom_range(59) == 0) begin
				req_bus.valid <= 1'b0;
				drain_sched(0);
			end
		end

		set_config(BE_W'($urandom), EB_W'($urandom));
		for (int i = 0; i < 60; i++) begin
			if (i == 30) begin
				// hold off until the schedule is fully drained
				req_bus.valid <= 1'b0;
				drain_sched(0);
			end
			push_random_req();
		end

		// Stretch with no idling on either side
		set_config(21'h10_0000, 5'd16);
		no_idle <= 1'b1;
		repeat (40) push_random_req();
		no_idle <= 1'b0;

		req_bus.valid <= 1'b0;
		drain_sched(SETTLE_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
